FILE: rtl/dmc_pkg.sv
// ============================================================================
// dmc_pkg: shared types and codes for the depth-first maze carver
// Item and result layouts, event and action codes, and the command and
// status groups between the carver controller and its datapath.
// ============================================================================
package dmc_pkg;

    localparam int SIDE_W = 6;

    typedef struct packed {
        logic        action;
        logic [14:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [6:0] wall_x;
        logic [6:0] wall_y;
        logic [4:0] cur_x;
        logic [4:0] cur_y;
        logic [9:0] remaining;
        logic       finished;
    } t_out_item;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_CARVE = 2'd1;
    localparam logic [1:0] EV_BACK  = 2'd2;
    localparam logic [1:0] EV_IDLE  = 2'd3;

    localparam logic [1:0] RD_CUR  = 2'd0;
    localparam logic [1:0] RD_DOWN = 2'd1;
    localparam logic [1:0] RD_UP   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clr_init;
        logic       clr_step;
        logic       start_commit;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       latch_c;
        logic       latch_d;
        logic       carve;
        logic       pop_rd;
        logic       emit_back;
        logic       pop_load;
        logic       emit_idle;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic has_move;
        logic stack_nz;
        logic rem_zero;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/dmc_datapath.sv
// ============================================================================
// dmc_datapath: visited map, return stack and position state of the carver
// Holds the row-organized visited memory, the return stack memory, the
// current cell, counters and the result register.
// ============================================================================
module dmc_datapath #(
    parameter int MAX_SIDE = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dmc_pkg::t_in_item           i_in_data,
    input  logic                        i_cfg_wr_en,
    input  logic [dmc_pkg::SIDE_W-1:0]  i_cfg_wr_data,
    input  dmc_pkg::t_dp_cmd            i_cmd,
    output dmc_pkg::t_dp_sts            o_sts,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output dmc_pkg::t_out_item          o_out_data
);
    import dmc_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int EW    = 2 * CW;
    localparam int GW    = CW + 2;

    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_XM = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

    function automatic logic [1:0] f_mod3(input logic [14:0] v);
        logic [15:0] w;
        logic [4:0]  s;
        logic [2:0]  t;
        w = {1'b0, v};
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(w[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    logic [SIDE_W-1:0]   r_cfg_side;
    logic [SW-1:0]       r_side;
    logic [CW-1:0]       r_cx;
    logic [CW-1:0]       r_cy;
    logic [DW-1:0]       r_rem;
    logic [DW-1:0]       r_depth;
    logic [CW-1:0]       r_clr_row;
    logic [14:0]         r_rnd;
    logic [1:0]          r_rnd_m3;
    logic [MAX_SIDE-1:0] r_row_c;
    logic [MAX_SIDE-1:0] r_row_d;
    logic [MAX_SIDE-1:0] r_vis [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_vis_q;
    logic [EW-1:0]       r_stk [CELLS];
    logic [EW-1:0]       r_stk_q;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;

    logic [SW-1:0]       w_start_side;
    logic [2*SW-1:0]     w_sq;
    logic [DW-1:0]       w_start_rem;
    logic                w_ok_xp, w_ok_xm, w_ok_yp, w_ok_ym;
    logic [CW-1:0]       w_xp, w_xm, w_yp, w_ym;
    logic [CW-1:0]       w_rd_addr;
    logic [3:0]          w_cand;
    logic [2:0]          w_cnt;
    logic [1:0]          w_sel;
    logic [2:0]          w_k;
    logic [1:0]          w_dir;
    logic [CW-1:0]       w_nx, w_ny;
    logic [GW-1:0]       w_wx, w_wy;
    logic [GW-1:0]       w_cx2, w_cy2;
    logic [MAX_SIDE-1:0] w_new_row;
    logic [MAX_SIDE-1:0] w_clr_data;
    logic [DW-1:0]       w_top;
    logic                w_push_ok;
    logic                w_emit;

    // side clamp and cell count for a new maze
    always_comb begin
        if (r_cfg_side == '0) begin
            w_start_side = SW'(1);
        end else if (int'(r_cfg_side) > MAX_SIDE) begin
            w_start_side = SW'(MAX_SIDE);
        end else begin
            w_start_side = SW'(r_cfg_side);
        end
    end

    assign w_sq        = {{SW{1'b0}}, w_start_side} * {{SW{1'b0}}, w_start_side};
    assign w_start_rem = DW'(w_sq - 1'b1);

    // neighbor bounds
    assign w_ok_xp = (int'(r_cx) + 1) < int'(r_side);
    assign w_ok_xm = (r_cx != '0);
    assign w_ok_yp = (int'(r_cy) + 1) < int'(r_side);
    assign w_ok_ym = (r_cy != '0);
    assign w_xp    = w_ok_xp ? r_cx + CW'(1) : r_cx;
    assign w_xm    = w_ok_xm ? r_cx - CW'(1) : r_cx;
    assign w_yp    = w_ok_yp ? r_cy + CW'(1) : r_cy;
    assign w_ym    = w_ok_ym ? r_cy - CW'(1) : r_cy;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_CUR:  w_rd_addr = r_cy;
            RD_DOWN: w_rd_addr = w_yp;
            RD_UP:   w_rd_addr = w_ym;
            default: w_rd_addr = r_cy;
        endcase
    end

    // row above the current cell is still in the read register during evaluation
    assign w_cand[0] = w_ok_xp && !r_row_c[w_xp];
    assign w_cand[1] = w_ok_xm && !r_row_c[w_xm];
    assign w_cand[2] = w_ok_yp && !r_row_d[r_cx];
    assign w_cand[3] = w_ok_ym && !r_vis_q[r_cx];
    assign w_cnt     = 3'($countones(w_cand));

    always_comb begin
        case (w_cnt)
            3'd2:    w_sel = {1'b0, r_rnd[0]};
            3'd3:    w_sel = r_rnd_m3;
            3'd4:    w_sel = r_rnd[1:0];
            default: w_sel = 2'd0;
        endcase
    end

    always_comb begin
        w_k   = '0;
        w_dir = DIR_XP;
        for (int i = 0; i < 4; i++) begin
            if (w_cand[i]) begin
                if (w_k == {1'b0, w_sel}) begin
                    w_dir = 2'(i);
                end
                w_k = w_k + 3'd1;
            end
        end
    end

    assign w_cx2 = GW'({r_cx, 1'b0});
    assign w_cy2 = GW'({r_cy, 1'b0});

    always_comb begin
        case (w_dir)
            DIR_XM: begin
                w_nx      = w_xm;
                w_ny      = r_cy;
                w_wx      = w_cx2;
                w_wy      = w_cy2 + GW'(1);
                w_new_row = r_row_c;
            end
            DIR_YP: begin
                w_nx      = r_cx;
                w_ny      = w_yp;
                w_wx      = w_cx2 + GW'(1);
                w_wy      = w_cy2 + GW'(2);
                w_new_row = r_row_d;
            end
            DIR_YM: begin
                w_nx      = r_cx;
                w_ny      = w_ym;
                w_wx      = w_cx2 + GW'(1);
                w_wy      = w_cy2;
                w_new_row = r_vis_q;
            end
            default: begin
                w_nx      = w_xp;
                w_ny      = r_cy;
                w_wx      = w_cx2 + GW'(2);
                w_wy      = w_cy2 + GW'(1);
                w_new_row = r_row_c;
            end
        endcase
        w_new_row[w_nx] = 1'b1;
    end

    assign w_clr_data = (r_clr_row == '0) ? MAX_SIDE'(1) : '0;
    assign w_top      = r_depth - DW'(1);
    assign w_push_ok  = int'(r_depth) < CELLS;

    // visited rows
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_vis[r_clr_row] <= w_clr_data;
        end else if (i_cmd.carve) begin
            r_vis[w_ny] <= w_new_row;
        end
        if (i_cmd.rd_en) begin
            r_vis_q <= r_vis[w_rd_addr];
        end
    end

    // return stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.carve && w_push_ok) begin
            r_stk[r_depth[AW-1:0]] <= {r_cy, r_cx};
        end
        if (i_cmd.pop_rd) begin
            r_stk_q <= r_stk[w_top[AW-1:0]];
        end
    end

    // payload holding registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rnd    <= i_in_data.random_value;
            r_rnd_m3 <= f_mod3(i_in_data.random_value);
        end
        if (i_cmd.latch_c) begin
            r_row_c <= r_vis_q;
        end
        if (i_cmd.latch_d) begin
            r_row_d <= r_vis_q;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_side <= SIDE_W'(32);
            r_side     <= SW'(1);
            r_cx       <= '0;
            r_cy       <= '0;
            r_rem      <= '0;
            r_depth    <= '0;
            r_clr_row  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_side <= i_cfg_wr_data;
            end
            if (i_cmd.clr_init) begin
                r_clr_row <= CW'(MAX_SIDE - 1);
            end else if (i_cmd.clr_step && r_clr_row != '0) begin
                r_clr_row <= r_clr_row - CW'(1);
            end
            if (i_cmd.start_commit) begin
                r_side  <= w_start_side;
                r_cx    <= '0;
                r_cy    <= '0;
                r_depth <= '0;
                r_rem   <= w_start_rem;
            end else if (i_cmd.carve) begin
                r_cx  <= w_nx;
                r_cy  <= w_ny;
                r_rem <= r_rem - DW'(1);
                if (w_push_ok) begin
                    r_depth <= r_depth + DW'(1);
                end
            end else if (i_cmd.pop_rd) begin
                r_depth <= w_top;
            end else if (i_cmd.pop_load) begin
                r_cx <= r_stk_q[CW-1:0];
                r_cy <= r_stk_q[EW-1:CW];
            end
        end
    end

    // result assembly
    assign w_emit = i_cmd.start_commit | i_cmd.carve | i_cmd.emit_back |
                    i_cmd.pop_load | i_cmd.emit_idle;

    always_comb begin
        n_out            = '0;
        n_out.cur_x      = 5'(r_cx);
        n_out.cur_y      = 5'(r_cy);
        n_out.remaining  = 10'(r_rem);
        n_out.finished   = (r_rem == '0);
        if (i_cmd.start_commit) begin
            n_out.event_kind = EV_START;
            n_out.cur_x      = '0;
            n_out.cur_y      = '0;
            n_out.remaining  = 10'(w_start_rem);
            n_out.finished   = (w_start_rem == '0);
        end else if (i_cmd.carve) begin
            n_out.event_kind = EV_CARVE;
            n_out.wall_x     = 7'(w_wx);
            n_out.wall_y     = 7'(w_wy);
            n_out.cur_x      = 5'(w_nx);
            n_out.cur_y      = 5'(w_ny);
            n_out.remaining  = 10'(r_rem - DW'(1));
            n_out.finished   = (r_rem == DW'(1));
        end else if (i_cmd.pop_load) begin
            n_out.event_kind = EV_BACK;
            n_out.cur_x      = 5'(r_stk_q[CW-1:0]);
            n_out.cur_y      = 5'(r_stk_q[EW-1:CW]);
        end else if (i_cmd.emit_back) begin
            n_out.event_kind = EV_BACK;
        end else begin
            n_out.event_kind = EV_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_sts.clr_last = (r_clr_row == '0);
    assign o_sts.has_move = |w_cand;
    assign o_sts.stack_nz = (r_depth != '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    a_carve_needs_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve |-> r_rem != '0)
        else $error("carve with no unvisited cell left");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_rd |-> r_depth != '0)
        else $error("pop from empty return stack");

    a_push_grows_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.carve && w_push_ok) |=> r_depth == $past(r_depth) + DW'(1))
        else $error("return stack depth did not advance on carve");

endmodule

FILE: rtl/dmc_ctrl.sv
// ============================================================================
// dmc_ctrl: sequencing state machine of the maze carver
// Accepts items, runs the visited-map clear sweep, the three row reads of a
// step, the carve or backtrack decision and the stack pop.
// ============================================================================
module dmc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    output logic              o_in_stall,
    output dmc_pkg::t_dp_cmd  o_cmd,
    input  dmc_pkg::t_dp_sts  i_sts
);
    import dmc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_RD_C = 3'd3;
    localparam logic [2:0] S_RD_D = 3'd4;
    localparam logic [2:0] S_RD_U = 3'd5;
    localparam logic [2:0] S_EVAL = 3'd6;
    localparam logic [2:0] S_POP  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_action == ACT_START) begin
                        o_cmd.clr_init = 1'b1;
                        n_state        = S_CLR;
                    end else if (i_sts.rem_zero) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RD_C;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last && i_sts.out_free) begin
                    o_cmd.start_commit = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_idle = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RD_C: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_RD_D;
            end
            S_RD_D: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_DOWN;
                o_cmd.latch_c = 1'b1;
                n_state       = S_RD_U;
            end
            S_RD_U: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_UP;
                o_cmd.latch_d = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    if (i_sts.has_move) begin
                        o_cmd.carve = 1'b1;
                        n_state     = S_IDLE;
                    end else if (i_sts.stack_nz) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end else begin
                        o_cmd.emit_back = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.pop_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_reads_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_action == ACT_STEP && !i_sts.rem_zero) |=> r_state == S_RD_C)
        else $error("step did not start the row reads");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.carve, o_cmd.pop_rd, o_cmd.emit_back, o_cmd.pop_load,
                  o_cmd.emit_idle, o_cmd.start_commit}))
        else $error("more than one outcome in a cycle");

    a_eval_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_RD_U || $past(r_state) == S_EVAL))
        else $error("evaluation entered without the row reads");

endmodule

FILE: rtl/dfs_maze_carver.sv
// ============================================================================
// dfs_maze_carver: randomized depth-first maze carver
// Start and step items drive a recursive backtracker over a square grid of
// cells; each item returns one event with the carved wall and position.
// ============================================================================
// One item is worked at a time. A step that carves a wall or reports a stuck
// backtrack passes the states RD_C, RD_D, RD_U and EVAL before its result is
// registered, a step that pops the return stack adds POP, and a step once the
// maze is finished goes to FIN alone: the visited map lives in a single-port
// memory of MAX_SIDE rows, and the current row and the rows below and above
// are read one after another before the move is chosen; a pop adds one read
// of the return stack memory. A start item sweeps the visited map one row per
// cycle. The next item is taken while a result still waits on the output; the
// block only holds a finished result when the output register is still full.
module dfs_maze_carver #(
    parameter int MAX_SIDE = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dmc_pkg::t_in_item           i_in_data,
    input  logic                        i_cfg_wr_en,
    input  logic [dmc_pkg::SIDE_W-1:0]  i_cfg_wr_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dmc_pkg::t_out_item          o_out_data
);
    import dmc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    dmc_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule
